/* rtl/fm_emphasis_filter_defines.svh */
// assertion macros for the fm emphasis filter
// used by the sequencer; depends on nothing else
`ifndef FM_EMPHASIS_FILTER_DEFINES_SVH
`define FM_EMPHASIS_FILTER_DEFINES_SVH

// antecedent holds in a cycle, consequent in the same cycle
`define FME_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle, consequent in the next one
`define FME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fme_pkg.sv */
// shared types, constants and the control store of the fm emphasis filter
// no dependencies
package fme_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int STATE_W  = 32;
    localparam int ACC_W    = 34;
    localparam int MUL_A_W  = GAIN_W + 1;
    localparam int PROD_W   = MUL_A_W + ACC_W;
    localparam int PC_W     = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_EMPH  = 2'd1;
    localparam logic [1:0] REG_HP    = 2'd2;
    localparam logic [1:0] REG_GAIN  = 2'd3;

    localparam logic [COEF_W-1:0] EMPH_RESET = 16'd63012;
    localparam logic [COEF_W-1:0] HP_RESET   = 16'd63061;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd495390;

    typedef struct packed {
        logic              mode;
        logic [COEF_W-1:0] emph_factor;
        logic [COEF_W-1:0] hp_factor;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_DIFF,
        OP_INTEG,
        OP_HPSUM,
        OP_HPOUT,
        OP_OUT_PRE,
        OP_OUT_DE
    } op_t;

    typedef enum logic [1:0] {
        A_EF,
        A_HP,
        A_GAIN
    } asel_t;

    typedef enum logic [1:0] {
        B_PREV,
        B_INTEG,
        B_ACC,
        B_HPP
    } bsel_t;

    typedef enum logic [1:0] {
        FL_NEXT,
        FL_BR_MODE,
        FL_DONE
    } flow_t;

    typedef struct packed {
        op_t             op;
        asel_t           a_sel;
        bsel_t           b_sel;
        flow_t           flow;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic  load;
        logic  step_en;
        op_t   op;
        asel_t a_sel;
        bsel_t b_sel;
    } ctrl_t;

    localparam logic [PC_W-1:0] DE_START = 4'd5;

    // control store: pre-emphasis at 1..4, de-emphasis at 5..11
    function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, a_sel: A_EF, b_sel: B_PREV, flow: FL_DONE, target: '0};
        unique case (pc)
            4'd0:  w = '{OP_NOP,     A_EF,   B_PREV,  FL_BR_MODE, DE_START};
            4'd1:  w = '{OP_MUL,     A_EF,   B_PREV,  FL_NEXT,    '0};
            4'd2:  w = '{OP_DIFF,    A_EF,   B_PREV,  FL_NEXT,    '0};
            4'd3:  w = '{OP_MUL,     A_GAIN, B_ACC,   FL_NEXT,    '0};
            4'd4:  w = '{OP_OUT_PRE, A_EF,   B_PREV,  FL_DONE,    '0};
            4'd5:  w = '{OP_MUL,     A_EF,   B_INTEG, FL_NEXT,    '0};
            4'd6:  w = '{OP_INTEG,   A_EF,   B_PREV,  FL_NEXT,    '0};
            4'd7:  w = '{OP_HPSUM,   A_EF,   B_PREV,  FL_NEXT,    '0};
            4'd8:  w = '{OP_MUL,     A_HP,   B_ACC,   FL_NEXT,    '0};
            4'd9:  w = '{OP_HPOUT,   A_EF,   B_PREV,  FL_NEXT,    '0};
            4'd10: w = '{OP_MUL,     A_GAIN, B_HPP,   FL_NEXT,    '0};
            4'd11: w = '{OP_OUT_DE,  A_EF,   B_PREV,  FL_DONE,    '0};
            default: w = '{OP_NOP,   A_EF,   B_PREV,  FL_DONE,    '0};
        endcase
        return w;
    endfunction

endpackage

/* rtl/fme_regs.sv */
// configuration registers behind the apb port
// depends on fme_pkg
module fme_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fme_pkg::ADDR_W-1:0] paddr,
    input  logic [fme_pkg::DATA_W-1:0] pwdata,
    output logic [fme_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output fme_pkg::cfg_t              cfg
);
    import fme_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode        <= 1'b0;
            cfg_reg.emph_factor <= EMPH_RESET;
            cfg_reg.hp_factor   <= HP_RESET;
            cfg_reg.gain        <= GAIN_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE: cfg_reg.mode        <= pwdata[0];
                REG_EMPH: cfg_reg.emph_factor <= pwdata[COEF_W-1:0];
                REG_HP:   cfg_reg.hp_factor   <= pwdata[COEF_W-1:0];
                REG_GAIN: cfg_reg.gain        <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.mode};
            REG_EMPH: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.emph_factor};
            REG_HP:   prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.hp_factor};
            REG_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain};
            default:  prdata = '0;
        endcase
    end

endmodule

/* rtl/fme_seq.sv */
// microcode sequencer: step counter, control store fetch, handshakes
// depends on fme_pkg and the assertion macro header
`include "fm_emphasis_filter_defines.svh"

module fme_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 mode,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output fme_pkg::ctrl_t       ctrl
);
    import fme_pkg::*;

    logic            busy_reg,      busy_next;
    logic [PC_W-1:0] pc_reg,        pc_next;
    logic            out_valid_reg, out_valid_next;
    ucode_t          cw;
    logic            accept;
    logic            done_step;
    logic            stall;
    logic            step_en;

    assign cw        = ucode_word(pc_reg);
    assign accept    = s_tvalid & ~busy_reg;
    assign done_step = busy_reg & (cw.flow == FL_DONE);
    // the last step waits while the previous word still sits in the output register
    assign stall     = done_step & out_valid_reg & ~m_tready;
    assign step_en   = busy_reg & ~stall;

    assign s_tready  = ~busy_reg;
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        ctrl.load    = accept;
        ctrl.step_en = step_en;
        ctrl.op      = cw.op;
        ctrl.a_sel   = cw.a_sel;
        ctrl.b_sel   = cw.b_sel;
    end

    always_comb begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        if (accept) begin
            pc_next   = '0;
            busy_next = 1'b1;
        end else if (step_en) begin
            unique case (cw.flow)
                FL_NEXT:    pc_next = pc_reg + 1'b1;
                FL_BR_MODE: pc_next = mode ? cw.target : pc_reg + 1'b1;
                FL_DONE: begin
                    pc_next        = '0;
                    busy_next      = 1'b0;
                    out_valid_next = 1'b1;
                end
                default:    pc_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FME_ASSERT_NEXT(a_accept_starts, aclk, aresetn, accept, busy_reg && pc_reg == '0, "accepted word did not start the program")
    `FME_ASSERT_NEXT(a_stall_holds, aclk, aresetn, stall, busy_reg && $stable(pc_reg), "stalled last step moved on")
    `FME_ASSERT_SAME(a_valid_from_done, aclk, aresetn, $rose(out_valid_reg), $past(done_step), "result appeared without a last step")
    `FME_ASSERT_SAME(a_busy_ends_at_done, aclk, aresetn, $fell(busy_reg), $past(done_step && !stall), "program ended away from its last step")

endmodule

/* rtl/fme_datapath.sv */
// shared multiplier datapath with filter state and output register
// depends on fme_pkg
module fme_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fme_pkg::cfg_t                cfg,
    input  fme_pkg::ctrl_t               ctrl,
    input  logic [fme_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                         last_in,
    output logic [fme_pkg::SAMPLE_W-1:0] sample_out,
    output logic                         last_out
);
    import fme_pkg::*;

    localparam logic signed [PROD_W-1:0] S32_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32_LO = PROD_W'(-64'sd2147483648);
    localparam logic signed [PROD_W-1:0] S16_HI = PROD_W'(64'sd32767);
    localparam logic signed [PROD_W-1:0] S16_LO = PROD_W'(-64'sd32768);

    // arithmetic shift right, rounding toward zero
    function automatic logic signed [PROD_W-1:0] trunc_shr(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? ((PROD_W'(1) << sh) - PROD_W'(1)) : '0;
        return (v + $signed(bias)) >>> sh;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > S32_HI)
            r = S32_HI[STATE_W-1:0];
        else if (v < S32_LO)
            r = S32_LO[STATE_W-1:0];
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > S16_HI)
            r = S16_HI[SAMPLE_W-1:0];
        else if (v < S16_LO)
            r = S16_LO[SAMPLE_W-1:0];
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [STATE_W-1:0]  integ_reg;
    logic signed [STATE_W-1:0]  hpp_reg,  hpp_next;
    logic signed [STATE_W-1:0]  y_reg,    y_next;
    logic signed [ACC_W-1:0]    acc_reg,  acc_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] out_reg,  out_next;
    logic                       out_last_reg;

    logic [MUL_A_W-1:0]         mul_a;
    logic signed [ACC_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   t16;
    logic signed [PROD_W-1:0]   x_q24;
    logic signed [ACC_W-1:0]    diff;
    logic signed [ACC_W-1:0]    hpsum;

    always_comb begin
        unique case (ctrl.a_sel)
            A_EF:    mul_a = {{(MUL_A_W-COEF_W){1'b0}}, cfg.emph_factor};
            A_HP:    mul_a = {{(MUL_A_W-COEF_W){1'b0}}, cfg.hp_factor};
            A_GAIN:  mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain};
            default: mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            B_PREV:  mul_b = {{(ACC_W-SAMPLE_W){prev_reg[SAMPLE_W-1]}}, prev_reg};
            B_INTEG: mul_b = {{(ACC_W-STATE_W){integ_reg[STATE_W-1]}}, integ_reg};
            B_ACC:   mul_b = acc_reg;
            B_HPP:   mul_b = {{(ACC_W-STATE_W){hpp_reg[STATE_W-1]}}, hpp_reg};
            default: mul_b = '0;
        endcase
    end

    assign prod_next = $signed(mul_a) * mul_b;

    // exact pre-emphasis difference in q17.16
    assign diff  = $signed({{(ACC_W-SAMPLE_W-16){x_reg[SAMPLE_W-1]}}, x_reg, 16'h0000})
                   - $signed(prod_reg[ACC_W-1:0]);
    assign t16   = trunc_shr(prod_reg, 16);
    assign x_q24 = $signed({{(PROD_W-SAMPLE_W-9){x_reg[SAMPLE_W-1]}}, x_reg, 9'h000});
    assign y_next = sat32(x_q24 + t16);
    assign hpsum = $signed({{(ACC_W-STATE_W){hpp_reg[STATE_W-1]}}, hpp_reg})
                   + $signed({{(ACC_W-STATE_W){y_reg[STATE_W-1]}}, y_reg})
                   - $signed({{(ACC_W-STATE_W){integ_reg[STATE_W-1]}}, integ_reg});
    assign hpp_next = sat32(t16);
    assign acc_next = (ctrl.op == OP_DIFF) ? diff : hpsum;
    assign out_next = (ctrl.op == OP_OUT_PRE) ? sat16(trunc_shr(prod_reg, 32))
                                              : sat16(trunc_shr(prod_reg, 25));

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            integ_reg <= '0;
            hpp_reg   <= '0;
        end else if (ctrl.step_en) begin
            unique case (ctrl.op)
                OP_DIFF:  prev_reg  <= x_reg;
                OP_HPSUM: integ_reg <= y_reg;
                OP_HPOUT: hpp_reg   <= hpp_next;
                default: ;
            endcase
        end
    end

    // working and output registers
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x_reg    <= $signed(sample_in);
            last_reg <= last_in;
        end
        if (ctrl.step_en) begin
            unique case (ctrl.op)
                OP_MUL:   prod_reg <= prod_next;
                OP_DIFF:  acc_reg  <= acc_next;
                OP_HPSUM: acc_reg  <= acc_next;
                OP_INTEG: y_reg    <= y_next;
                OP_OUT_PRE, OP_OUT_DE: begin
                    out_reg      <= out_next;
                    out_last_reg <= last_reg;
                end
                default: ;
            endcase
        end
    end

    assign sample_out = out_reg;
    assign last_out   = out_last_reg;

endmodule

/* rtl/fm_emphasis_filter.sv */
// top level of the fm pre-emphasis / de-emphasis filter
// depends on fme_pkg, fme_regs, fme_seq and fme_datapath
//
// One signed q15 sample enters on the s_ stream and one filtered, saturated
// sample leaves on the m_ stream; tlast is carried from input to output.
// Register mode picks pre-emphasis (0) or de-emphasis with high-pass (1);
// mode, emph_factor, hp_factor and gain sit at apb byte addresses 0, 4, 8
// and 12, written by the user only while the block is idle (not enforced).
// A short control program steps one shared 25 x 34 bit multiplier; the
// program is longer in de-emphasis than in pre-emphasis. A new sample is
// taken in the cycle after the previous one finishes, so the block never
// runs the program for two samples at once. The program length is set by
// the number of dependent multiply and add steps in it.
// Reset clears the filter history, restores the register defaults and
// empties the output register. A result waits in the output register while
// m_tready is low; the next sample is accepted and computed meanwhile and
// only its final step waits until the output register has been emptied.
module fm_emphasis_filter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [15:0] sample_in
    input  logic                       s_tlast,   // last_in
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // [15:0] sample_out
    output logic                       m_tlast,   // last_out
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fme_pkg::ADDR_W-1:0] paddr,
    input  logic [fme_pkg::DATA_W-1:0] pwdata,
    output logic [fme_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import fme_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;

    fme_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fme_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (cfg.mode),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    fme_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .ctrl       (ctrl),
        .sample_in  (s_tdata),
        .last_in    (s_tlast),
        .sample_out (m_tdata),
        .last_out   (m_tlast)
    );

endmodule

/* test/tb_fm_emphasis_filter.sv */
`timescale 1ns / 1ps
// self-checking testbench for fm_emphasis_filter: a directed table, then random words
// under four flow-control phases; each output word is checked against a behavioural
// filter or a pinned table result; depends on fme_pkg and the rtl top level only
module tb_fm_emphasis_filter;
    import fme_pkg::*;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     SEGMENTS       = 8;
    localparam int     WORDS_PER_SEG  = 235;
    localparam int     PLAN_LEN       = 27;
    localparam longint Q15_MAX        = 32767;
    localparam longint Q15_MIN        = -32768;
    localparam longint ACC_MAX        = 64'sd2147483647;
    localparam longint ACC_MIN        = -64'sd2147483648;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic [31:0] value;
        logic        last;
        bit          fixed;
        logic [15:0] result;
    } plan_row_t;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } filtered_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [15:0] sample_in
    logic              s_tlast;   // last_in
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;   // [15:0] sample_out
    logic              m_tlast;   // last_out
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // settings and filter history as the block should hold them
    logic              f_mode = 1'b0;
    logic [COEF_W-1:0] f_emph = EMPH_RESET;
    logic [COEF_W-1:0] f_hp   = HP_RESET;
    logic [GAIN_W-1:0] f_gain = GAIN_RESET;
    longint            prev_x    = 0;
    longint            integ_acc = 0;
    longint            hp_acc    = 0;

    filtered_t   pending_q[$];
    plan_row_t   plan [PLAN_LEN];
    int          errors     = 0;
    int          quiet      = 0;
    int          send_idle  = 0;
    int          sink_stall = 0;
    bit          pin_result = 1'b0;
    logic [15:0] pinned     = '0;

    fm_emphasis_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_tready <= (sink_stall == 0) || ($urandom_range(99) >= sink_stall);
    end

    // shift right rounding toward zero
    function automatic longint trunc_shift(input longint v, input int sh);
        if (v >= 0)
            return v >>> sh;
        return -((-v) >>> sh);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one sample through the selected filter; only that filter's history moves
    function automatic logic [15:0] filter_step(input logic [15:0] raw);
        logic signed [15:0] xs;
        longint             x, d, y, s, z, r;
        xs = raw;
        x  = xs;
        if (f_mode == 1'b0) begin
            d      = x * 65536 - longint'(f_emph) * prev_x;
            prev_x = x;
            r      = clamp(trunc_shift(longint'(f_gain) * d, 32), Q15_MIN, Q15_MAX);
        end else begin
            y = clamp(x * 512 + trunc_shift(longint'(f_emph) * integ_acc, 16),
                      ACC_MIN, ACC_MAX);
            s = hp_acc + y - integ_acc;
            z = clamp(trunc_shift(longint'(f_hp) * s, 16), ACC_MIN, ACC_MAX);
            integ_acc = y;
            hp_acc    = z;
            r = clamp(trunc_shift(longint'(f_gain) * z, 25), Q15_MIN, Q15_MAX);
        end
        return r[15:0];
    endfunction

    // mostly audio of random amplitude, with full-scale words mixed in
    function automatic logic [15:0] audio_word();
        int span;
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: begin
                span = $urandom_range(0, 15);
                return 16'($urandom_range(0, (2 << span) - 1) - (1 << span));
            end
        endcase
    endfunction

    // register value with junk above the field: zero, all ones, default or near it
    function automatic logic [31:0] corner_pick(input int bits, input logic [31:0] typical);
        logic [31:0] word, mask;
        word = $urandom;
        mask = (32'd1 << bits) - 1;
        case ($urandom_range(0, 5))
            0: word = word & ~mask;
            1: word = word | mask;
            2: word = (word & ~mask) | typical;
            default: word = (word & ~mask) | ($urandom_range(0, 2 * typical) & mask);
        endcase
        return word;
    endfunction

    task automatic reg_write(input logic [1:0] sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_MODE: f_mode = value[0];
            REG_EMPH: f_emph = value[COEF_W-1:0];
            REG_HP:   f_hp   = value[COEF_W-1:0];
            REG_GAIN: f_gain = value[GAIN_W-1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // valid stays high between back-to-back words, dropped only for a gap
    task automatic push_word(input logic [15:0] sample, input logic last, input bit fixed,
                             input logic [15:0] result);
        bit taken;
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pin_result = fixed;
        pinned     = result;
        s_tvalid  <= 1'b1;
        s_tdata   <= sample;
        s_tlast   <= last;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // handshakes sampled mid-cycle, so they hold for the coming rising edge
    always @(negedge aclk) begin : watch
        filtered_t   want;
        logic [15:0] calc;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    errors++;
                    $error("output word with none expected: sample_out %0d",
                           $signed(m_tdata));
                end else begin
                    want = pending_q.pop_front();
                    if (m_tdata !== want.sample) begin
                        errors++;
                        $error("sample_out mismatch: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_tdata));
                    end
                    if (m_tlast !== want.last) begin
                        errors++;
                        $error("last_out mismatch: expected %0d, got %0d",
                               want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                calc        = filter_step(s_tdata);
                want.sample = pin_result ? pinned : calc;
                want.last   = s_tlast;
                pending_q.push_back(want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] word;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        plan = '{
            // pre-emphasis at default settings: silence, full scale, saturation both ways
            '{ROW_SAMPLE, REG_MODE, 32'h0000_0000, 1'b0, 1'b1, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_7FFF, 1'b0, 1'b1, 16'h7FFF},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_8000, 1'b1, 1'b1, 16'h8000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_0000, 1'b0, 1'b1, 16'h7FFF},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_0000, 1'b0, 1'b1, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_0001, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
            // junk above the field must be dropped
            '{ROW_WRITE,  REG_EMPH, 32'hABCD_0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_3039, 1'b0, 1'b0, 16'h0000},
            '{ROW_WRITE,  REG_GAIN, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_FFFE, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_7FFF, 1'b1, 1'b1, 16'h7FFF},
            '{ROW_WRITE,  REG_GAIN, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_8000, 1'b0, 1'b1, 16'h0000},
            // de-emphasis; pre-emphasis history must survive untouched
            '{ROW_WRITE,  REG_MODE, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_WRITE,  REG_GAIN, {8'h00, GAIN_RESET}, 1'b0, 1'b0, 16'h0000},
            '{ROW_WRITE,  REG_EMPH, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_7FFF, 1'b0, 1'b1, 16'h7FFF},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_8000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_8000, 1'b0, 1'b0, 16'h0000},
            '{ROW_WRITE,  REG_HP,   32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_03E8, 1'b0, 1'b1, 16'h0000},
            '{ROW_WRITE,  REG_HP,   32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_0000, 1'b1, 1'b0, 16'h0000},
            '{ROW_WRITE,  REG_MODE, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, REG_MODE, 32'h0000_0000, 1'b0, 1'b0, 16'h0000}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                reg_write(plan[i].sel, plan[i].value);
            end else begin
                push_word(plan[i].value[15:0], plan[i].last, plan[i].fixed, plan[i].result);
            end
        end

        // first half pre-emphasis, second half de-emphasis, each over all flow phases
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            case (seg % 4)
                0: begin
                    send_idle  = 0;
                    sink_stall = 0;
                end
                1: begin
                    send_idle  = 82;
                    sink_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    sink_stall = 82;
                end
                default: begin
                    send_idle  = 34;
                    sink_stall = 34;
                end
            endcase
            word    = $urandom;
            word[0] = seg[2];
            reg_write(REG_MODE, word);
            reg_write(REG_EMPH, corner_pick(COEF_W, EMPH_RESET));
            reg_write(REG_HP, corner_pick(COEF_W, HP_RESET));
            reg_write(REG_GAIN, corner_pick(GAIN_W, GAIN_RESET));
            for (int n = 0; n < WORDS_PER_SEG; n++)
                push_word(audio_word(), $urandom_range(0, 7) == 0, 1'b0, '0);
        end

        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* fm_emphasis_filter.f */
+incdir+rtl
rtl/fme_pkg.sv
rtl/fme_regs.sv
rtl/fme_seq.sv
rtl/fme_datapath.sv
rtl/fm_emphasis_filter.sv
test/tb_fm_emphasis_filter.sv
